### rtl/core/pwb_pkg.sv
// pwb_pkg: shared types, fixed-point constants and helpers of the white-balance block
// depends on nothing; imported by every module under rtl/core
`default_nettype none

package pwb_pkg;

    localparam int DEFAULT_CHANNEL_BITS = 8;

    // q3.13 sample, 1.0 = 8192
    typedef logic signed [15:0] q13_t;
    // matrix and warm coefficients, q13
    typedef logic signed [15:0] coef_t;
    typedef coef_t coef_mat_t [3][3];
    // mix factor, q3.12
    typedef logic signed [14:0] mix_t;
    // tint amount added to q, q13
    typedef logic signed [13:0] qadd_t;

    // derived coefficients handed from the register block to the datapath
    typedef struct packed {
        mix_t  mix;
        qadd_t qadd;
    } wb_coef_t;

    localparam int ONE_Q13  = 8192;
    localparam int HALF_Q13 = 4096;
    localparam int Q_LIMIT  = 4281;
    localparam int TINT_K   = 280569;

    localparam coef_mat_t TO_YIQ = '{
        '{ 16'sd2449,  16'sd4809,   16'sd934 },
        '{ 16'sd4882, -16'sd2245,  -16'sd2638 },
        '{ 16'sd1737, -16'sd4284,   16'sd2548 }
    };
    localparam coef_mat_t TO_RGB = '{
        '{ 16'sd8192,  16'sd7832,   16'sd5087 },
        '{ 16'sd8192, -16'sd2228,  -16'sd5300 },
        '{ 16'sd8192, -16'sd9052,   16'sd13943 }
    };
    localparam coef_t WARM [3] = '{ 16'sd7619, 16'sd4424, 16'sd0 };

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam logic [0:0] REG_KELVIN = 1'b0;
    localparam logic [0:0] REG_TINT   = 1'b1;

    localparam int KELVIN_MIN   = 1000;
    localparam int KELVIN_MAX   = 40000;
    localparam int KELVIN_REF   = 5000;
    localparam int KELVIN_RESET = 5000;
    localparam logic signed [10:0] TINT_MIN = -11'sd1000;
    localparam logic signed [10:0] TINT_MAX = 11'sd1000;

    // mix factor: (d * slope + bias) / 100000, low slope scaled by ten
    localparam int MIX_SLOPE_LO = 163840;
    localparam int MIX_SLOPE_HI = 24576;
    localparam int MIX_BIAS     = 50000;
    localparam int MIX_DIV      = 100000;
    localparam int MIX_SHIFT    = 30;
    localparam int MIX_RECIP    = (1 << MIX_SHIFT) / MIX_DIV;

    function automatic q13_t sat_q13(input logic signed [39:0] v);
        q13_t r;
        if (v > 40'sd32767)
            r = 16'sd32767;
        else if (v < -40'sd32768)
            r = -16'sd32768;
        else
            r = $signed(v[15:0]);
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/pwb_regs.sv
// pwb_regs: apb register file (kelvin, tint) and the pipelines deriving mix factor and q offset
// depends on pwb_pkg
`default_nettype none

module pwb_regs
    import pwb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output wb_coef_t              coef
);

    logic [15:0]        kelvin_reg, kelvin_next;
    logic signed [10:0] tint_reg, tint_next;
    logic               wr_en;
    logic [15:0]        kw;
    logic signed [10:0] tw;

    // mix factor pipeline
    logic               lo1_reg, lo1_next;
    logic [15:0]        d1_reg, d1_next;
    logic               lo2_reg;
    logic [29:0]        num2_reg, num2_next;
    logic               lo3_reg;
    logic [29:0]        num3_reg;
    logic [43:0]        prod3_reg, prod3_next;
    logic [13:0]        q4;
    logic [30:0]        r4;
    logic [13:0]        qc4;
    logic signed [14:0] qs4;
    mix_t               mix_reg, mix_next;

    // tint pipeline
    logic signed [29:0] tp_reg, tp_next;
    qadd_t              qadd_reg, qadd_next;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign kw     = pwdata[15:0];
    assign tw     = $signed(pwdata[10:0]);

    always_comb
    begin
        kelvin_next = kelvin_reg;
        tint_next   = tint_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_KELVIN:
                begin
                    if (kw < 16'(KELVIN_MIN))
                        kelvin_next = 16'(KELVIN_MIN);
                    else if (kw > 16'(KELVIN_MAX))
                        kelvin_next = 16'(KELVIN_MAX);
                    else
                        kelvin_next = kw;
                end
                REG_TINT:
                begin
                    if (tw < TINT_MIN)
                        tint_next = TINT_MIN;
                    else if (tw > TINT_MAX)
                        tint_next = TINT_MAX;
                    else
                        tint_next = tw;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_KELVIN: prdata = {16'd0, kelvin_reg};
            REG_TINT:   prdata = {{21{tint_reg[10]}}, tint_reg};
        endcase
    end

    // distance from the reference temperature, side selects the slope
    assign lo1_next  = kelvin_reg < 16'(KELVIN_REF);
    assign d1_next   = lo1_next ? 16'(KELVIN_REF) - kelvin_reg : kelvin_reg - 16'(KELVIN_REF);
    assign num2_next = 30'(34'(d1_reg) * (lo1_reg ? 34'(MIX_SLOPE_LO) : 34'(MIX_SLOPE_HI)))
                       + 30'(MIX_BIAS);
    assign prod3_next = 44'(num2_reg) * 44'(MIX_RECIP);

    // reciprocal estimate is low by at most one
    assign q4   = prod3_reg[43:30];
    assign r4   = 31'(num3_reg) - 31'(q4) * 31'(MIX_DIV);
    assign qc4  = (r4 >= 31'(MIX_DIV)) ? q4 + 14'd1 : q4;
    assign qs4  = $signed({1'b0, qc4});
    assign mix_next = lo3_reg ? -qs4 : qs4;

    assign tp_next   = 30'(31'(tint_reg) * 31'(TINT_K));
    assign qadd_next = qadd_t'((tp_reg + 30'sd32768) >>> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kelvin_reg <= 16'(KELVIN_RESET);
            tint_reg   <= '0;
            lo1_reg    <= 1'b0;
            d1_reg     <= '0;
            lo2_reg    <= 1'b0;
            num2_reg   <= '0;
            lo3_reg    <= 1'b0;
            num3_reg   <= '0;
            prod3_reg  <= '0;
            mix_reg    <= '0;
            tp_reg     <= '0;
            qadd_reg   <= '0;
        end
        else
        begin
            kelvin_reg <= kelvin_next;
            tint_reg   <= tint_next;
            lo1_reg    <= lo1_next;
            d1_reg     <= d1_next;
            lo2_reg    <= lo1_reg;
            num2_reg   <= num2_next;
            lo3_reg    <= lo2_reg;
            num3_reg   <= num2_reg;
            prod3_reg  <= prod3_next;
            mix_reg    <= mix_next;
            tp_reg     <= tp_next;
            qadd_reg   <= qadd_next;
        end
    end

    assign coef.mix  = mix_reg;
    assign coef.qadd = qadd_reg;

endmodule

`default_nettype wire

### rtl/core/pwb_norm.sv
// pwb_norm: two-stage conversion of three channels to q13, round(c * 8192 / max)
// depends on pwb_pkg
`default_nettype none

module pwb_norm
    import pwb_pkg::*;
#(
    parameter int CHANNEL_BITS = DEFAULT_CHANNEL_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  logic [CHANNEL_BITS-1:0] chan_in [3],
    output logic                    valid_out,
    output logic [13:0]             c_out [3]
);

    localparam int CH_MAX = (1 << CHANNEL_BITS) - 1;
    localparam int DIV    = 2 * CH_MAX;
    localparam int SHIFT  = CHANNEL_BITS + 14;
    localparam int NUM_W  = CHANNEL_BITS + 14;
    localparam int PROD_W = NUM_W + 14;
    localparam int RECIP  = (1 << SHIFT) / DIV;

    logic v1_reg, v2_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        logic [NUM_W-1:0]  num_reg, num_next;
        logic [PROD_W-1:0] prod_reg, prod_next;
        logic [13:0]       q;
        logic [NUM_W-1:0]  r;
        logic [13:0]       c_reg, c_next;

        assign num_next  = {chan_in[i], 14'd0} + NUM_W'(CH_MAX);
        assign prod_next = PROD_W'(num_next) * PROD_W'(RECIP);

        // estimate is low by at most one
        assign q      = prod_reg[SHIFT +: 14];
        assign r      = num_reg - NUM_W'(q) * NUM_W'(DIV);
        assign c_next = (r >= NUM_W'(DIV)) ? q + 14'd1 : q;

        always_ff @(posedge clk)
        begin
            num_reg  <= num_next;
            prod_reg <= prod_next;
            c_reg    <= c_next;
        end

        assign c_out[i] = c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    assign valid_out = v2_reg;

endmodule

`default_nettype wire

### rtl/core/pwb_mat.sv
// pwb_mat: 3x3 q13 color matrix, products in one stage, sum round and saturate in the next
// depends on pwb_pkg
`default_nettype none

module pwb_mat
    import pwb_pkg::*;
#(
    parameter coef_mat_t COEF = TO_YIQ
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic valid_in,
    input  q13_t vec_in [3],
    output logic valid_out,
    output q13_t vec_out [3]
);

    logic v1_reg, v2_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_row
        logic signed [33:0] sum;
        logic signed [33:0] rnd;
        q13_t               out_reg, out_next;

        for (genvar j = 0; j < 3; j++)
        begin : g_col
            logic signed [31:0] prod_reg, prod_next;
            assign prod_next = 32'(vec_in[j]) * 32'(COEF[i][j]);
            always_ff @(posedge clk)
            begin
                prod_reg <= prod_next;
            end
        end

        assign sum      = 34'(g_col[0].prod_reg) + 34'(g_col[1].prod_reg)
                          + 34'(g_col[2].prod_reg);
        assign rnd      = (sum + 34'sd4096) >>> 13;
        assign out_next = sat_q13(40'(rnd));

        always_ff @(posedge clk)
        begin
            out_reg <= out_next;
        end

        assign vec_out[i] = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    assign valid_out = v2_reg;

endmodule

`default_nettype wire

### rtl/core/pwb_blend.sv
// pwb_blend: overlay with the warm color, mix by the temperature factor, scale to channel codes
// four stages; depends on pwb_pkg
`default_nettype none

module pwb_blend
    import pwb_pkg::*;
#(
    parameter int CHANNEL_BITS = DEFAULT_CHANNEL_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  q13_t                    x_in [3],
    input  mix_t                    mix,
    output logic                    valid_out,
    output logic [CHANNEL_BITS-1:0] chan_out [3]
);

    localparam int CH_MAX = (1 << CHANNEL_BITS) - 1;
    localparam int SC_W   = CHANNEL_BITS + 14;

    logic valid_pipe_reg [4];

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam logic signed [33:0] W2  = 34'(WARM[i]) <<< 1;
        localparam logic signed [33:0] W2B = (34'sd8192 - 34'(WARM[i])) <<< 1;

        logic signed [33:0]       pa, pb;
        q13_t                     p_reg, p_next;
        q13_t                     x1_reg, x2_reg;
        logic signed [16:0]       diff;
        logic signed [31:0]       prod_reg, prod_next;
        q13_t                     m_reg, m_next;
        logic [SC_W-1:0]          scaled;
        logic [CHANNEL_BITS-1:0]  ch_reg, ch_next;

        // overlay: multiply below one half, screen above
        assign pa = (34'(x_in[i]) * W2 + 34'sd4096) >>> 13;
        assign pb = 34'sd8192
                    - (((34'sd8192 - 34'(x_in[i])) * W2B + 34'sd4096) >>> 13);
        assign p_next = sat_q13(40'((x_in[i] < 16'sd4096) ? pa : pb));

        // linear mix toward the overlay result
        assign diff      = 17'(p_reg) - 17'(x1_reg);
        assign prod_next = 32'(diff) * 32'(mix);
        assign m_next    = sat_q13(40'(34'(x2_reg) + ((34'(prod_reg) + 34'sd2048) >>> 12)));

        // q13 to channel code with saturation
        assign scaled = (SC_W'(m_reg[12:0]) * SC_W'(CH_MAX) + SC_W'(4096)) >> 13;
        always_comb
        begin
            if (m_reg <= 16'sd0)
                ch_next = '0;
            else if (m_reg >= 16'sd8192)
                ch_next = CHANNEL_BITS'(CH_MAX);
            else
                ch_next = CHANNEL_BITS'(scaled);
        end

        always_ff @(posedge clk)
        begin
            p_reg    <= p_next;
            x1_reg   <= x_in[i];
            prod_reg <= prod_next;
            x2_reg   <= x1_reg;
            m_reg    <= m_next;
            ch_reg   <= ch_next;
        end

        assign chan_out[i] = ch_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                valid_pipe_reg[k] <= 1'b0;
        end
        else
        begin
            valid_pipe_reg[0] <= valid_in;
            for (int k = 1; k < 4; k++)
                valid_pipe_reg[k] <= valid_pipe_reg[k-1];
        end
    end

    assign valid_out = valid_pipe_reg[3];

endmodule

`default_nettype wire

### rtl/core/pixel_white_balance.sv
// pixel_white_balance: accepts one item per clock sustained; each item leaves with done
// stages: 2 normalize, 2 rgb-to-yiq, 1 tint, 2 yiq-to-rgb, 4 overlay/mix/scale; never stalls
// busy stays low and done pulses for one cycle per item; the receiver cannot hold results off
// reset clears all valid bits and sets temperature to 5000 K and tint to 0
// a write reaches the tint offset via tint_reg, tp_reg, qadd_reg; mix via its own pipeline
// depends on pwb_pkg, pwb_regs, pwb_norm, pwb_mat, pwb_blend
`default_nettype none

module pixel_white_balance
    import pwb_pkg::*;
#(
    parameter int CHANNEL_BITS = DEFAULT_CHANNEL_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // item in
    input  logic                    start,
    output logic                    busy,
    input  logic [CHANNEL_BITS-1:0] red_in,
    input  logic [CHANNEL_BITS-1:0] green_in,
    input  logic [CHANNEL_BITS-1:0] blue_in,
    input  logic [CHANNEL_BITS-1:0] alpha_in,
    // item out
    output logic                    done,
    output logic [CHANNEL_BITS-1:0] red_out,
    output logic [CHANNEL_BITS-1:0] green_out,
    output logic [CHANNEL_BITS-1:0] blue_out,
    output logic [CHANNEL_BITS-1:0] alpha_out
);

    // total pipeline depth, alpha rides a delay line of the same length
    localparam int LAT = 11;

    wb_coef_t                coef;
    logic                    in_valid;
    logic [CHANNEL_BITS-1:0] rgb_in [3];
    logic                    norm_valid;
    logic [13:0]             norm_c [3];
    q13_t                    norm_q [3];
    logic                    yiq_valid;
    q13_t                    yiq [3];
    logic signed [16:0]      q_sum;
    q13_t                    q_next;
    logic                    tint_valid_reg;
    q13_t                    tint_vec_reg [3];
    logic                    rgb_valid;
    q13_t                    rgb [3];
    logic [CHANNEL_BITS-1:0] chan_out [3];
    logic [CHANNEL_BITS-1:0] alpha_pipe_reg [LAT];

    // the datapath takes an item in every cycle
    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    assign rgb_in[0] = red_in;
    assign rgb_in[1] = green_in;
    assign rgb_in[2] = blue_in;

    // registers and derived coefficients
    pwb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // channel codes to q13
    pwb_norm #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid),
        .chan_in   (rgb_in),
        .valid_out (norm_valid),
        .c_out     (norm_c)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_norm_q
        assign norm_q[i] = $signed({2'b00, norm_c[i]});
    end

    // rgb to yiq
    pwb_mat #(
        .COEF (TO_YIQ)
    ) u_to_yiq (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (norm_valid),
        .vec_in    (norm_q),
        .valid_out (yiq_valid),
        .vec_out   (yiq)
    );

    // tint shifts q, then q is clamped to the chroma limit
    assign q_sum = 17'(yiq[2]) + 17'(coef.qadd);
    always_comb
    begin
        if (q_sum > 17'(Q_LIMIT))
            q_next = 16'(Q_LIMIT);
        else if (q_sum < -17'(Q_LIMIT))
            q_next = -16'(Q_LIMIT);
        else
            q_next = 16'(q_sum);
    end

    always_ff @(posedge clk)
    begin
        tint_vec_reg[0] <= yiq[0];
        tint_vec_reg[1] <= yiq[1];
        tint_vec_reg[2] <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tint_valid_reg <= 1'b0;
        else
            tint_valid_reg <= yiq_valid;
    end

    // yiq back to rgb
    pwb_mat #(
        .COEF (TO_RGB)
    ) u_to_rgb (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (tint_valid_reg),
        .vec_in    (tint_vec_reg),
        .valid_out (rgb_valid),
        .vec_out   (rgb)
    );

    // temperature: overlay, mix and output scaling; last stage is the output register
    pwb_blend #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (rgb_valid),
        .x_in      (rgb),
        .mix       (coef.mix),
        .valid_out (done),
        .chan_out  (chan_out)
    );

    // alpha delay line matching the pipeline depth
    always_ff @(posedge clk)
    begin
        alpha_pipe_reg[0] <= alpha_in;
        for (int k = 1; k < LAT; k++)
            alpha_pipe_reg[k] <= alpha_pipe_reg[k-1];
    end

    assign red_out   = chan_out[0];
    assign green_out = chan_out[1];
    assign blue_out  = chan_out[2];
    assign alpha_out = alpha_pipe_reg[LAT-1];

    // every accepted item is answered by done
    a_item_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted item did not complete on time");

    // no result without a matching accepted item
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching item");

    // alpha travels with its item
    a_alpha_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (alpha_out == $past(alpha_in, LAT)))
        else $error("alpha out of step with its item");

endmodule

`default_nettype wire
